/* rtl/avcp_pkg.sv */
// ----------------------------------------------------------------------------
// avcp_pkg: shared types and codes of the configuration record parser
// Phase codes (which double as field kinds), parser state and result word.
// ----------------------------------------------------------------------------
package avcp_pkg;

    // phase codes; the tag of a byte is the phase it was taken in
    localparam logic [3:0] PH_VER       = 4'd0;
    localparam logic [3:0] PH_PROF      = 4'd1;
    localparam logic [3:0] PH_COMPAT    = 4'd2;
    localparam logic [3:0] PH_LEVEL     = 4'd3;
    localparam logic [3:0] PH_LENSIZE   = 4'd4;
    localparam logic [3:0] PH_SPSCNT    = 4'd5;
    localparam logic [3:0] PH_SPSLEN_HI = 4'd6;
    localparam logic [3:0] PH_SPSLEN_LO = 4'd7;
    localparam logic [3:0] PH_SPSDATA   = 4'd8;
    localparam logic [3:0] PH_PPSCNT    = 4'd9;
    localparam logic [3:0] PH_PPSLEN_HI = 4'd10;
    localparam logic [3:0] PH_PPSLEN_LO = 4'd11;
    localparam logic [3:0] PH_PPSDATA   = 4'd12;
    localparam logic [3:0] PH_TRAIL     = 4'd13;

    localparam logic [7:0] LENSIZE_MASK = 8'h03;
    localparam logic [7:0] SPSCNT_MASK  = 8'h1f;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  sets_left;
        logic [7:0]  set_idx;
        logic [15:0] set_len;
        logic [15:0] pay_off;
    } parse_state_t;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [7:0]  field_value;
        logic [7:0]  set_index;
        logic [15:0] byte_in_set;
        logic [15:0] set_length;
        logic        record_done;
        logic        parse_error;
        logic [23:0] consumed;
    } field_res_t;

endpackage

/* rtl/avcp_in_if.sv */
// ----------------------------------------------------------------------------
// avcp_in_if: byte channel into the parser
// One word is one record byte plus the end-of-buffer flag.
// ----------------------------------------------------------------------------
interface avcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/avcp_out_if.sv */
// ----------------------------------------------------------------------------
// avcp_out_if: tagged field channel out of the parser
// One word is the tag, position and status of one record byte.
// ----------------------------------------------------------------------------
interface avcp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  field_kind;
    logic [7:0]  field_value;
    logic [7:0]  set_index;
    logic [15:0] byte_in_set;
    logic [15:0] set_length;
    logic        record_done;
    logic        parse_error;
    logic [23:0] consumed;

    modport source (output valid, output field_kind, output field_value,
                    output set_index, output byte_in_set, output set_length,
                    output record_done, output parse_error, output consumed,
                    input ready);
    modport sink   (input valid, input field_kind, input field_value,
                    input set_index, input byte_in_set, input set_length,
                    input record_done, input parse_error, input consumed,
                    output ready);
endinterface

/* rtl/avcp_step.sv */
// ----------------------------------------------------------------------------
// avcp_step: per-byte parse step
// Tags one byte and computes the next parser state and byte count.
// ----------------------------------------------------------------------------
module avcp_step #(
    parameter int COUNT_WIDTH = 24
) (
    input  avcp_pkg::parse_state_t   st,
    input  logic [COUNT_WIDTH-1:0]   cnt,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    output avcp_pkg::parse_state_t   st_next,
    output logic [COUNT_WIDTH-1:0]   cnt_next,
    output avcp_pkg::field_res_t     res
);
    import avcp_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;

    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [EXT_W-1:0]       cnt_ext;
    logic [7:0]             sl_dec;
    logic [15:0]            len_full;
    logic [16:0]            off_inc;
    logic                   close_set;
    logic                   is_pps;
    logic                   done;

    always_comb
    begin
        st_next   = st;
        close_set = 1'b0;
        is_pps    = 1'b0;
        done      = 1'b0;
        sl_dec    = st.sets_left - 8'd1;
        len_full  = {st.set_len[15:8], data_byte};
        off_inc   = {1'b0, st.pay_off} + 17'd1;

        res             = '0;
        res.field_kind  = st.phase;
        res.field_value = data_byte;

        // trailing bytes do not count; the count saturates
        cnt_inc = cnt;
        if ((st.phase != PH_TRAIL) && !(&cnt))
        begin
            cnt_inc = cnt + COUNT_WIDTH'(1);
        end

        unique case (st.phase) inside
            PH_VER, PH_PROF, PH_COMPAT, PH_LEVEL:
            begin
                st_next.phase = st.phase + 4'd1;
            end
            PH_LENSIZE:
            begin
                res.field_value = data_byte & LENSIZE_MASK;
                st_next.phase   = PH_SPSCNT;
            end
            PH_SPSCNT:
            begin
                res.field_value   = data_byte & SPSCNT_MASK;
                st_next.sets_left = data_byte & SPSCNT_MASK;
                st_next.set_idx   = '0;
                st_next.phase     = ((data_byte & SPSCNT_MASK) != 8'd0) ? PH_SPSLEN_HI
                                                                        : PH_PPSCNT;
            end
            PH_PPSCNT:
            begin
                st_next.sets_left = data_byte;
                st_next.set_idx   = '0;
                if (data_byte == 8'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    st_next.phase = PH_PPSLEN_HI;
                end
            end
            PH_SPSLEN_HI, PH_PPSLEN_HI:
            begin
                res.set_index   = st.set_idx;
                st_next.set_len = {data_byte, 8'd0};
                st_next.phase   = st.phase + 4'd1;
            end
            PH_SPSLEN_LO, PH_PPSLEN_LO:
            begin
                res.set_index   = st.set_idx;
                res.set_length  = len_full;
                st_next.set_len = len_full;
                st_next.pay_off = '0;
                is_pps          = (st.phase == PH_PPSLEN_LO);
                if (len_full == 16'd0)
                begin
                    close_set = 1'b1;
                end
                else
                begin
                    st_next.phase = st.phase + 4'd1;
                end
            end
            PH_SPSDATA, PH_PPSDATA:
            begin
                res.set_index   = st.set_idx;
                res.byte_in_set = st.pay_off;
                res.set_length  = st.set_len;
                st_next.pay_off = off_inc[15:0];
                is_pps          = (st.phase == PH_PPSDATA);
                close_set       = (off_inc >= {1'b0, st.set_len});
            end
            default:
            begin
                res.field_kind = PH_TRAIL;
            end
        endcase

        if (close_set)
        begin
            st_next.sets_left = sl_dec;
            st_next.set_idx   = st.set_idx + 8'd1;
            if (sl_dec != 8'd0)
            begin
                st_next.phase = is_pps ? PH_PPSLEN_HI : PH_SPSLEN_HI;
            end
            else if (is_pps)
            begin
                done = 1'b1;
            end
            else
            begin
                st_next.phase = PH_PPSCNT;
            end
        end

        cnt_ext         = EXT_W'(cnt_inc);
        res.consumed    = cnt_ext[23:0];
        res.record_done = done;
        cnt_next        = cnt_inc;

        if (done)
        begin
            if (last_byte)
            begin
                st_next  = '0;
                cnt_next = '0;
            end
            else
            begin
                st_next.phase = PH_TRAIL;
            end
        end
        else if (last_byte)
        begin
            res.parse_error = (res.field_kind != PH_TRAIL);
            st_next         = '0;
            cnt_next        = '0;
        end
    end

endmodule

/* rtl/avc_config_record_parser_core.sv */
// ----------------------------------------------------------------------------
// avc_config_record_parser_core: AVC decoder configuration record byte tagger
// The tagged word is shown after its byte has passed the input register and
// the result register (two register stages).
// Throughput 1 word per cycle when not stalled; parse step is the only loop.
// Reset (rst_n, async low) empties both stages and returns to the version byte.
// ----------------------------------------------------------------------------
module avc_config_record_parser_core #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    avcp_in_if.sink           bytes,
    avcp_out_if.source        fields
);
    import avcp_pkg::*;

    // Two register stages: the input register holds one byte, the result
    // register holds one tagged word. The parse step between them also
    // advances the record state, so state moves only when a byte passes
    // from the input register into the result register.

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_last_reg;

    logic                   out_valid_reg;
    field_res_t             res_reg;

    parse_state_t           st_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;

    parse_state_t           st_next;
    logic [COUNT_WIDTH-1:0] cnt_next;
    field_res_t             res_next;

    logic                   out_adv;
    logic                   s1_fire;
    logic                   in_fire;

    // result register can load when empty or being drained this cycle
    assign out_adv     = !out_valid_reg || fields.ready;
    assign s1_fire     = s1_valid_reg && out_adv;
    assign bytes.ready = !s1_valid_reg || out_adv;
    assign in_fire     = bytes.valid && bytes.ready;

    avcp_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .st        (st_reg),
        .cnt       (cnt_reg),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .st_next   (st_next),
        .cnt_next  (cnt_next),
        .res       (res_next)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (bytes.ready)
            begin
                s1_valid_reg <= bytes.valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                st_reg  <= st_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= bytes.data_byte;
            s1_last_reg <= bytes.last_byte;
        end
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign fields.valid       = out_valid_reg;
    assign fields.field_kind  = res_reg.field_kind;
    assign fields.field_value = res_reg.field_value;
    assign fields.set_index   = res_reg.set_index;
    assign fields.byte_in_set = res_reg.byte_in_set;
    assign fields.set_length  = res_reg.set_length;
    assign fields.record_done = res_reg.record_done;
    assign fields.parse_error = res_reg.parse_error;
    assign fields.consumed    = res_reg.consumed;

    // end of buffer always leaves the parser idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (st_reg.phase == PH_VER) && (cnt_reg == '0))
        else $error("parser not idle after end of buffer");

    // trailing bytes never advance the byte count
    a_trail_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_last_reg && (st_reg.phase == PH_TRAIL)) |=> $stable(cnt_reg))
        else $error("byte count moved on trailing byte");

    // a failure is never flagged on a trailing or completing word
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (fields.valid && fields.parse_error)
            |-> (fields.field_kind != PH_TRAIL) && !fields.record_done)
        else $error("parse error on trailing or completing word");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for avc_config_record_parser_core
// Drives record buffers byte by byte: directed header, empty-list, zero-length,
// trailing and short-buffer cases, a record with a long set, then random
// well-formed, truncated, padded and noise buffers. A local model tags every
// accepted byte and the scoreboard checks each output word against it.
// ----------------------------------------------------------------------------
module testbench;
    import avcp_pkg::*;

    // Count width below the parser's default of 24
    localparam int COUNT_W        = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic clk = 1'b0;
    logic rst_n;

    avcp_in_if  byte_ch ();
    avcp_out_if field_ch ();

    avc_config_record_parser_core #(
        .COUNT_WIDTH (COUNT_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .fields (field_ch)
    );

    always #2 clk = ~clk;

    // Parser model state; all zero is the idle state (waiting for version)
    parse_state_t       mdl       = '0;
    logic [COUNT_W-1:0] mdl_count = '0;

    field_res_t expected_tags[$];
    logic [7:0] rec_bytes[$];
    bit         idle_on     = 1'b1;
    int         sent_words  = 0;
    int         mismatches  = 0;
    int         stall_left  = 0;
    int         quiet_cycles = 0;

    // Close one parameter set. Returns 1 when the last picture set closes,
    // which completes the record.
    function automatic logic close_set(input logic is_pic);
        mdl.sets_left = mdl.sets_left - 8'd1;
        mdl.set_idx   = mdl.set_idx + 8'd1;
        if (mdl.sets_left != 8'd0) begin
            mdl.phase = is_pic ? PH_PPSLEN_HI : PH_SPSLEN_HI;
            return 1'b0;
        end
        if (is_pic)
            return 1'b1;
        mdl.phase = PH_PPSCNT;
        return 1'b0;
    endfunction

    // Tag one accepted byte and advance the model
    function automatic field_res_t tag_byte(input logic [7:0] b, input logic lst);
        field_res_t r;
        logic [3:0] cur;
        logic       fin;
        r   = '0;
        cur = mdl.phase;
        fin = 1'b0;
        r.field_kind  = cur;
        r.field_value = b;
        // trailing bytes do not count toward the record
        if (cur != PH_TRAIL && mdl_count != '1)
            mdl_count = mdl_count + 1'b1;
        case (cur)
            PH_VER, PH_PROF, PH_COMPAT, PH_LEVEL:
                mdl.phase = cur + 4'd1;
            PH_LENSIZE:
            begin
                r.field_value = b & LENSIZE_MASK;
                mdl.phase     = PH_SPSCNT;
            end
            PH_SPSCNT:
            begin
                r.field_value = b & SPSCNT_MASK;
                mdl.sets_left = b & SPSCNT_MASK;
                mdl.set_idx   = 8'd0;
                mdl.phase     = (mdl.sets_left != 8'd0) ? PH_SPSLEN_HI : PH_PPSCNT;
            end
            PH_PPSCNT:
            begin
                mdl.sets_left = b;
                mdl.set_idx   = 8'd0;
                if (b == 8'd0)
                    fin = 1'b1;
                else
                    mdl.phase = PH_PPSLEN_HI;
            end
            PH_SPSLEN_HI, PH_PPSLEN_HI:
            begin
                r.set_index = mdl.set_idx;
                mdl.set_len = {b, 8'h00};
                mdl.phase   = cur + 4'd1;
            end
            PH_SPSLEN_LO, PH_PPSLEN_LO:
            begin
                r.set_index  = mdl.set_idx;
                mdl.set_len  = {mdl.set_len[15:8], b};
                r.set_length = mdl.set_len;
                mdl.pay_off  = 16'd0;
                if (mdl.set_len == 16'd0)
                    fin = close_set(cur == PH_PPSLEN_LO);
                else
                    mdl.phase = cur + 4'd1;
            end
            PH_SPSDATA, PH_PPSDATA:
            begin
                r.set_index   = mdl.set_idx;
                r.byte_in_set = mdl.pay_off;
                r.set_length  = mdl.set_len;
                mdl.pay_off   = mdl.pay_off + 16'd1;
                if (mdl.pay_off >= mdl.set_len)
                    fin = close_set(cur == PH_PPSDATA);
            end
            default:
                r.field_kind = PH_TRAIL;
        endcase
        r.consumed    = 24'(mdl_count);
        r.record_done = fin;
        // buffer end before completion is an error, unless already trailing
        r.parse_error = lst && !fin && (r.field_kind != PH_TRAIL);
        if (lst)
        begin
            mdl       = '0;
            mdl_count = '0;
        end
        else if (fin)
            mdl.phase = PH_TRAIL;
        return r;
    endfunction

    // Scoreboard: predict on byte accept, check on field accept
    always @(posedge clk)
    begin : scoreboard
        field_res_t got, want;
        logic       bad;
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
                expected_tags.insert(expected_tags.size(),
                                     tag_byte(byte_ch.data_byte, byte_ch.last_byte));
            if (field_ch.valid && field_ch.ready)
            begin
                got.field_kind  = field_ch.field_kind;
                got.field_value = field_ch.field_value;
                got.set_index   = field_ch.set_index;
                got.byte_in_set = field_ch.byte_in_set;
                got.set_length  = field_ch.set_length;
                got.record_done = field_ch.record_done;
                got.parse_error = field_ch.parse_error;
                got.consumed    = field_ch.consumed;
                if (expected_tags.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word kind=%0d value=%h", $realtime,
                                 got.field_kind, got.field_value);
                end
                else
                begin
                    want = expected_tags.pop_front();
                    bad  = (got.field_kind  !== want.field_kind)  ||
                           (got.field_value !== want.field_value) ||
                           (got.set_index   !== want.set_index)   ||
                           (got.byte_in_set !== want.byte_in_set) ||
                           (got.set_length  !== want.set_length)  ||
                           (got.record_done !== want.record_done) ||
                           (got.parse_error !== want.parse_error) ||
                           (got.consumed    !== want.consumed);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: word differs\n",
                                      "  exp kind=%0d val=%h idx=%0d off=%0d len=%0d ",
                                      "done=%b err=%b cons=%0d\n",
                                      "  got kind=%0d val=%h idx=%0d off=%0d len=%0d ",
                                      "done=%b err=%b cons=%0d"}, $realtime,
                                     want.field_kind, want.field_value, want.set_index,
                                     want.byte_in_set, want.set_length, want.record_done,
                                     want.parse_error, want.consumed,
                                     got.field_kind, got.field_value, got.set_index,
                                     got.byte_in_set, got.set_length, got.record_done,
                                     got.parse_error, got.consumed);
                    end
                end
            end
        end
    end

    // Output back-pressure: random stall bursts start only while idling is on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            field_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            field_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
            field_ch.ready <= 1'b1;
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (field_ch.valid && field_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved in %0d cycles, %0d still pending",
                         WATCHDOG_LIMIT, expected_tags.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Send one byte; may open with an idle burst when idling is on
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= lst;
        do @(posedge clk); while (!byte_ch.ready);
        sent_words++;
    endtask

    // Send rec_bytes as one buffer, flagging the final byte
    task automatic send_buffer();
        for (int i = 0; i < rec_bytes.size(); i++)
            send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
    endtask

    // Sender holds off until every predicted word has come out
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_tags.size() != 0) @(posedge clk);
    endtask

    // Add one byte at the end of the buffer under construction
    task automatic add_rec_byte(input logic [7:0] b);
        rec_bytes.insert(rec_bytes.size(), b);
    endtask

    // Append one set: 16-bit big-endian length and random payload
    task automatic append_set(input int max_len);
        int len;
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 290)
                                           : $urandom_range(0, max_len);
        add_rec_byte(8'(len >> 8));
        add_rec_byte(8'(len));
        repeat (len) add_rec_byte(8'($urandom_range(0, 255)));
    endtask

    // Build one complete record with random header bytes and set lists
    task automatic build_record();
        bit many;
        int nsps, npps;
        rec_bytes.delete();
        many = ($urandom_range(0, 19) == 0);
        nsps = many ? $urandom_range(4, 31) : $urandom_range(0, 3);
        npps = many ? $urandom_range(4, 12) : $urandom_range(0, 3);
        // version, profile, compat, level, length size (reserved bits random)
        repeat (5) add_rec_byte(8'($urandom_range(0, 255)));
        add_rec_byte({3'($urandom_range(0, 7)), 5'(nsps)});
        repeat (nsps) append_set(many ? 2 : 8);
        add_rec_byte(8'(npps));
        repeat (npps) append_set(many ? 2 : 8);
    endtask

    // Minimal record: no sequence sets, no picture sets; masks on
    // length size and sequence count with all reserved bits set
    task automatic test_min_record();
        rec_bytes = '{8'hff, 8'h00, 8'h7f, 8'h80, 8'hff, 8'he0, 8'h00};
        send_buffer();
    endtask

    // Zero-length sequence set, two-byte picture set, then a trailing byte
    task automatic test_zero_len_and_trailing();
        rec_bytes = '{8'h01, 8'h42, 8'hc0, 8'h1e, 8'hfc, 8'he1, 8'h00, 8'h00,
                      8'h01, 8'h00, 8'h02, 8'hff, 8'h00, 8'haa};
        send_buffer();
    endtask

    // Buffer far shorter than a header
    task automatic test_short_buffer();
        rec_bytes = '{8'h01, 8'h4d, 8'h40};
        send_buffer();
    endtask

    // One sequence set of 300 bytes, so both length bytes matter;
    // a trailing byte after completion keeps the final count
    task automatic test_long_set();
        send_byte(8'h01, 1'b0);
        send_byte(8'h64, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1f, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'he1, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h2c, 1'b0);
        repeat (300) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5a, 1'b1);
    endtask

    // Random buffers: mostly well-formed records, some padded with trailing
    // bytes, some cut short, some pure noise
    task automatic test_random_buffers(input int n_words, input bit allow_idle);
        int stop_at, shape, cut;
        stop_at = sent_words + n_words;
        while (sent_words < stop_at)
        begin
            idle_on = allow_idle && ($urandom_range(0, 4) != 0);
            shape   = $urandom_range(0, 9);
            if (shape == 9)
            begin
                rec_bytes.delete();
                repeat ($urandom_range(1, 10))
                    add_rec_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                build_record();
                if (shape >= 6 && shape <= 7)
                    repeat ($urandom_range(1, 3))
                        add_rec_byte(8'($urandom_range(0, 255)));
                else if (shape == 8)
                begin
                    cut = $urandom_range(1, rec_bytes.size() - 1);
                    while (rec_bytes.size() > cut)
                        void'(rec_bytes.pop_back());
                end
            end
            send_buffer();
        end
        idle_on = allow_idle;
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        byte_ch.valid      <= 1'b0;
        byte_ch.data_byte  <= 8'h00;
        byte_ch.last_byte  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_min_record();
        test_zero_len_and_trailing();
        test_short_buffer();
        wait_drained();
        test_long_set();
        wait_drained();
        test_random_buffers(1000, 1'b1);
        wait_drained();
        // closing stretch runs at full rate on both sides
        idle_on = 1'b0;
        test_random_buffers(150, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
